>>> rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the stereo feedback echo: register
// indexes, reset values, damping weights, sequencer states, lane controls.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

   // default sizes
   localparam int DELAY_DEPTH_DEF  = 131072;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // register widths
   localparam int DELAY_W     = 17;
   localparam int GAIN_W      = 16;
   localparam int MIX_W       = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;

   // register reset values
   localparam int DELAY_RESET    = 24000;
   localparam int FEEDBACK_RESET = 32768;
   localparam int MIX_RESET      = 32768;

   // damping weights in Q0.15, they sum to exactly 2^15
   localparam int DAMP_PREV = 22938;
   localparam int DAMP_NEW  = 9830;

   // unity in Q0.16
   localparam int UNITY_Q16 = 65536;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY    = 2'd0,
      CSR_FEEDBACK = 2'd1,
      CSR_MIX      = 2'd2
   } csr_index_type;

   // frame sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_SUM1,
      ST_MUL2,
      ST_WRITE,
      ST_DONE
   } seq_state_type;

   // per-step strobes from the sequencer to both lanes
   typedef struct packed {
      logic rd_en;    // capture sample, read delay line
      logic rd_hit;   // read entry has been written since reset
      logic mul_en;   // damping and mix products
      logic sum_en;   // damping state and output sums
      logic fb_en;    // feedback product
      logic wr_en;    // write delay line
   } lane_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/sfe_chan_if.sv
// ----------------------------------------------------------------------------
// sfe_req_if / sfe_rsp_if
// Valid/ready channels carrying one stereo frame per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfe_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfe_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] left_out;
   logic signed [SAMPLE_WIDTH-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

>>> rtl/sfe_lane.sv
// ----------------------------------------------------------------------------
// sfe_lane
// One channel of the echo: delay-line memory, damping state, feedback
// write-back with saturation, and the dry/wet blend.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_lane
   import sfe_pkg::*;
#(
   parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lane_ctrl_type                       ctrl,
   input  wire logic [$clog2(DELAY_DEPTH)-1:0]      rd_addr,
   input  wire logic [$clog2(DELAY_DEPTH)-1:0]      wr_addr,
   input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
   input  wire logic [GAIN_W-1:0]                   feedback_gain,
   input  wire logic [MIX_W-1:0]                    mix_gain,
   output logic signed [SAMPLE_WIDTH-1:0]           sample_out
);

   localparam int SW = SAMPLE_WIDTH;
   localparam logic signed [15:0] K_PREV = 16'(DAMP_PREV);
   localparam logic signed [15:0] K_NEW  = 16'(DAMP_NEW);
   localparam logic signed [SW+16:0] DAMP_HALF = (SW+17)'(2**14);
   localparam logic signed [SW+18:0] MIX_HALF  = (SW+19)'(2**15);
   localparam logic signed [SW+16:0] FB_HALF   = (SW+17)'(2**15);

   // delay line
   logic signed [SW-1:0] mem [DELAY_DEPTH];
   logic signed [SW-1:0] rd_data_ff;
   logic                 hit_ff;
   logic signed [SW-1:0] in_ff;
   logic signed [SW-1:0] prev_ff;
   logic signed [SW-1:0] prev_in;
   logic signed [SW-1:0] out_ff;
   logic signed [SW-1:0] out_in;
   logic signed [SW-1:0] delayed;
   logic signed [SW-1:0] wr_data;

   // products
   logic signed [SW+15:0] damp_a_ff, damp_a_in;
   logic signed [SW+15:0] damp_b_ff, damp_b_in;
   logic signed [SW+17:0] mix_a_ff, mix_a_in;
   logic signed [SW+17:0] mix_b_ff, mix_b_in;
   logic signed [SW+16:0] fb_ff, fb_in;
   logic [MIX_W-1:0]      dry_gain;

   // sums
   logic signed [SW+16:0] damp_sum;
   logic signed [SW+18:0] mix_sum;
   logic signed [SW+16:0] fb_sum;
   logic signed [SW+1:0]  wr_sum;

   // memory: registered read, one write port
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // never-written entries read as zero
   assign delayed  = hit_ff ? rd_data_ff : '0;
   assign dry_gain = MIX_W'(UNITY_Q16) - mix_gain;

   // first multiply step: damping taps and blend taps
   assign damp_a_in = prev_ff * K_PREV;
   assign damp_b_in = delayed * K_NEW;
   assign mix_a_in  = in_ff * $signed({1'b0, dry_gain});
   assign mix_b_in  = delayed * $signed({1'b0, mix_gain});

   // round half up, then drop the fraction
   assign damp_sum = (SW+17)'(damp_a_ff) + (SW+17)'(damp_b_ff) + DAMP_HALF;
   assign mix_sum  = (SW+19)'(mix_a_ff) + (SW+19)'(mix_b_ff) + MIX_HALF;
   assign prev_in  = damp_sum[SW+14:15];
   assign out_in   = mix_sum[SW+15:16];

   // feedback product uses the freshly updated damping state
   assign fb_in  = prev_ff * $signed({1'b0, feedback_gain});
   assign fb_sum = fb_ff + FB_HALF;
   assign wr_sum = (SW+2)'(in_ff) + (SW+2)'($signed(fb_sum[SW+16:16]));

   // saturate to the sample range
   always_comb begin
      if (wr_sum[SW+1:SW-1] == 3'b000 || wr_sum[SW+1:SW-1] == 3'b111) begin
         wr_data = wr_sum[SW-1:0];
      end else if (wr_sum[SW+1]) begin
         wr_data = {1'b1, {(SW-1){1'b0}}};
      end else begin
         wr_data = {1'b0, {(SW-1){1'b1}}};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         in_ff  <= sample_in;
         hit_ff <= ctrl.rd_hit;
      end
      if (ctrl.mul_en) begin
         damp_a_ff <= damp_a_in;
         damp_b_ff <= damp_b_in;
         mix_a_ff  <= mix_a_in;
         mix_b_ff  <= mix_b_in;
      end
      if (ctrl.sum_en) begin
         out_ff <= out_in;
      end
      if (ctrl.fb_en) begin
         fb_ff <= fb_in;
      end
   end

   // damping state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (ctrl.sum_en) begin
         prev_ff <= prev_in;
      end
   end

   assign sample_out = out_ff;

endmodule

`default_nettype wire

>>> rtl/stereo_feedback_echo_unit.sv
// Sequencing: the frame sequencer walks both lanes through read, multiply, sum,
//   feedback multiply and write-back, then loads the result register, one frame
//   at a time; a new request is taken only in the idle state after the last result
//   is loaded, and the result load waits while a stalled result is still held.
// Reset: synchronous; registers return to their defaults, the write pointer
//   to zero, and a fill flag makes unwritten delay entries read as zero.
// ----------------------------------------------------------------------------
// stereo_feedback_echo_unit
// Two-lane feedback echo with damping; one stereo frame per request.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_echo_unit
   import sfe_pkg::*;
#(
   parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   sfe_req_if.sink                     req_chan,
   sfe_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int CW = (AW > DELAY_W ? AW : DELAY_W) + 1;

   seq_state_type state_ff, state_in;
   lane_ctrl_type ctrl;

   logic [DELAY_W-1:0] delay_ff;
   logic [GAIN_W-1:0]  fb_gain_ff;
   logic [MIX_W-1:0]   mix_ff;
   logic [MIX_W-1:0]   mix_eff;

   logic [AW-1:0] wr_ptr_ff;
   logic          wrapped_ff;
   logic [CW-1:0] delay_ext;
   logic [AW-1:0] delay_eff;
   logic [AW:0]   ptr_diff;
   logic [AW:0]   rd_wide;
   logic [AW-1:0] rd_addr;

   logic accept;
   logic rsp_free;
   logic rsp_load;
   logic rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] left_res, right_res;
   logic signed [SAMPLE_WIDTH-1:0] rsp_left_ff, rsp_right_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= DELAY_W'(DELAY_RESET);
         fb_gain_ff <= GAIN_W'(FEEDBACK_RESET);
         mix_ff     <= MIX_W'(MIX_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DELAY:    delay_ff   <= csr_wdata[DELAY_W-1:0];
            CSR_FEEDBACK: fb_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MIX:      mix_ff     <= csr_wdata[MIX_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp mix to unity and delay to one less than the line length
   assign mix_eff   = (mix_ff > MIX_W'(UNITY_Q16)) ? MIX_W'(UNITY_Q16) : mix_ff;
   assign delay_ext = CW'(delay_ff);
   assign delay_eff = (delay_ext > CW'(DELAY_DEPTH-1)) ? AW'(DELAY_DEPTH-1)
                                                       : delay_ext[AW-1:0];

   // read address: write pointer minus delay, modulo line length
   assign ptr_diff = {1'b0, wr_ptr_ff} - {1'b0, delay_eff};
   assign rd_wide  = ptr_diff[AW] ? ptr_diff + (AW+1)'(DELAY_DEPTH) : ptr_diff;
   assign rd_addr  = rd_wide[AW-1:0];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and lane strobes
   always_comb begin
      state_in    = state_ff;
      ctrl        = '0;
      ctrl.rd_hit = wrapped_ff || (rd_addr < wr_ptr_ff);
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.rd_en = 1'b1;
               state_in   = ST_MUL1;
            end
         end
         ST_MUL1: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_SUM1;
         end
         ST_SUM1: begin
            ctrl.sum_en = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            ctrl.fb_en = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            ctrl.wr_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // write pointer and fill flag
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         wrapped_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         if (wr_ptr_ff == AW'(DELAY_DEPTH-1)) begin
            wr_ptr_ff  <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
      end
   end

   // lanes
   sfe_lane #(
      .DELAY_DEPTH  (DELAY_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_lane_left (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_ptr_ff),
      .sample_in     (req_chan.left_in),
      .feedback_gain (fb_gain_ff),
      .mix_gain      (mix_eff),
      .sample_out    (left_res)
   );

   sfe_lane #(
      .DELAY_DEPTH  (DELAY_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_lane_right (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_ptr_ff),
      .sample_in     (req_chan.right_in),
      .feedback_gain (fb_gain_ff),
      .mix_gain      (mix_eff),
      .sample_out    (right_res)
   );

   // merge both lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_left_ff  <= left_res;
         rsp_right_ff <= right_res;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.left_out  = rsp_left_ff;
   assign rsp_chan.right_out = rsp_right_ff;

endmodule

`default_nettype wire

>>> rtl/sfe_checker.sv
// ----------------------------------------------------------------------------
// sfe_checker
// Port-level checks on the echo unit's request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_checker
   import sfe_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [SAMPLE_WIDTH-1:0] left_out,
   input wire logic signed [SAMPLE_WIDTH-1:0] right_out
);

   // no result pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_out) && $stable(right_out))
      else $error("stalled result changed");

   // one frame at a time: no request taken in the cycle after one is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a frame is in flight");

   // a result never appears in the cycle right after its request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind stereo_feedback_echo_unit sfe_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .left_out  (rsp_chan.left_out),
   .right_out (rsp_chan.right_out)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo feedback echo. Stereo frames go in over
// the request channel and outputs come back on the response channel. An echo
// model in the bench keeps its own delay lines, damping state and register
// copies. It predicts each output frame when its request is accepted and
// compares it field by field with what comes back. The run covers directed
// extremes, random phases under several pacing modes and a long receiver
// hold-off.
// ----------------------------------------------------------------------------

import sfe_pkg::*;

typedef struct packed {
   logic signed [SAMPLE_WIDTH_DEF-1:0] left;
   logic signed [SAMPLE_WIDTH_DEF-1:0] right;
} stereo_frame_type;

// Echo model plus the queue of predicted output frames
class echo_checker;
   bit signed [SAMPLE_WIDTH_DEF-1:0] left_line [DELAY_DEPTH_DEF];
   bit signed [SAMPLE_WIDTH_DEF-1:0] right_line [DELAY_DEPTH_DEF];
   longint      left_damp;
   longint      right_damp;
   int unsigned wr_ptr;
   int unsigned delay_reg;
   int unsigned feedback_reg;
   int unsigned mix_reg;
   stereo_frame_type predicted_frames [$];
   int unsigned errors;
   int unsigned responses_seen;

   function new();
      delay_reg    = DELAY_RESET;
      feedback_reg = FEEDBACK_RESET;
      mix_reg      = MIX_RESET;
   endfunction

   // register write as the block sees it; unknown indexes are dropped
   function void write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      case (idx)
         CSR_DELAY:    delay_reg    = value & ((1 << DELAY_W) - 1);
         CSR_FEEDBACK: feedback_reg = value & ((1 << GAIN_W) - 1);
         CSR_MIX:      mix_reg      = value & ((1 << MIX_W) - 1);
         default: ;
      endcase
   endfunction

   // round half up, then shift right by s
   function longint round_q(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // one channel: damping update, feedback write value and blended output
   function void echo_lane(input longint dry, input longint delayed, inout longint damp,
                           output longint stored, output longint blended);
      longint fb;
      longint mix;
      longint sum;
      longint smax;
      smax = (longint'(1) << (SAMPLE_WIDTH_DEF - 1)) - 1;
      damp = round_q(damp * DAMP_PREV + delayed * DAMP_NEW, 15);
      fb   = round_q(damp * longint'(feedback_reg), 16);
      sum  = dry + fb;
      if (sum > smax)
         stored = smax;
      else if (sum < -smax - 1)
         stored = -smax - 1;
      else
         stored = sum;
      mix = (mix_reg > UNITY_Q16) ? UNITY_Q16 : mix_reg;
      blended = round_q(dry * (UNITY_Q16 - mix) + delayed * mix, 16);
   endfunction

   // accepted request: predict its output frame and advance the lines
   function void note_request(stereo_frame_type frame);
      int unsigned      dly;
      int unsigned      rd_ptr;
      longint           stored;
      longint           blended;
      stereo_frame_type want;
      dly    = (delay_reg > DELAY_DEPTH_DEF - 1) ? DELAY_DEPTH_DEF - 1 : delay_reg;
      rd_ptr = (wr_ptr + DELAY_DEPTH_DEF - dly) % DELAY_DEPTH_DEF;
      // read before write, so a zero delay sees the oldest entry
      echo_lane(longint'(frame.left), longint'(left_line[rd_ptr]), left_damp,
                stored, blended);
      left_line[wr_ptr] = SAMPLE_WIDTH_DEF'(stored);
      want.left = SAMPLE_WIDTH_DEF'(blended);
      echo_lane(longint'(frame.right), longint'(right_line[rd_ptr]), right_damp,
                stored, blended);
      right_line[wr_ptr] = SAMPLE_WIDTH_DEF'(stored);
      want.right = SAMPLE_WIDTH_DEF'(blended);
      predicted_frames.push_back(want);
      wr_ptr = (wr_ptr + 1) % DELAY_DEPTH_DEF;
   endfunction

   // accepted response: compare with the oldest prediction
   function void check_response(stereo_frame_type got);
      stereo_frame_type want;
      if (predicted_frames.size() == 0) begin
         errors++;
         $error("response with no request outstanding: left_out %0d right_out %0d",
                got.left, got.right);
         return;
      end
      want = predicted_frames.pop_front();
      responses_seen++;
      if (got.left !== want.left) begin
         errors++;
         $error("left_out: expected %0d, got %0d", want.left, got.left);
      end
      if (got.right !== want.right) begin
         errors++;
         $error("right_out: expected %0d, got %0d", want.right, got.right);
      end
   endfunction

   function int pending();
      return predicted_frames.size();
   endfunction
endclass

module tb;

   localparam int SW             = SAMPLE_WIDTH_DEF;
   localparam int REG17_MAX      = (1 << DELAY_W) - 1;
   localparam int LATENCY_CYCLES = 5;
   localparam int TAIL_CYCLES    = 4 * LATENCY_CYCLES;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 11;
   localparam int PHASE_FRAMES   = 90;

   localparam logic [CSR_INDEX_W-1:0]  CSR_UNUSED = 2'd3;
   localparam logic signed [SW-1:0]    SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]    SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

   typedef enum int {
      PACE_STEADY,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH_IDLE
   } pace_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sfe_req_if #(.SAMPLE_WIDTH(SW)) req_chan ();
   sfe_rsp_if #(.SAMPLE_WIDTH(SW)) rsp_chan ();

   echo_checker      sb;
   stereo_frame_type stim_q [$];
   int unsigned      sent_count = 0;
   int               stall_pct = 0;
   logic             hold_pending = 1'b0;
   int unsigned      quiet_cycles = 0;

   stereo_feedback_echo_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // handshake monitor feeding the echo model
   always @(posedge clock) begin : monitor
      stereo_frame_type frame;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            frame.left  = req_chan.left_in;
            frame.right = req_chan.right_in;
            sb.note_request(frame);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            frame.left  = rsp_chan.left_out;
            frame.right = rsp_chan.right_out;
            sb.check_response(frame);
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending   <= 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog: too long without any request or response moving
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stereo_feedback_echo_unit: mismatch");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // one register write; the enable is dropped before the task returns, so writes never collide
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value[CSR_DATA_W-1:0];
      sb.write_reg(idx, value & ((1 << CSR_DATA_W) - 1));
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_frame(input int lval, input int rval);
      stereo_frame_type frame;
      frame.left  = lval[SW-1:0];
      frame.right = rval[SW-1:0];
      stim_q.push_back(frame);
   endtask

   // mostly full-range samples, with extremes and near-zero values mixed in
   function automatic logic signed [SW-1:0] pick_sample();
      logic signed [SW-1:0] s;
      case ($urandom_range(9))
         0: s = SAMPLE_MAX;
         1: s = SAMPLE_MIN;
         2: s = SW'(int'($urandom_range(0, 16)) - 8);
         default: s = SW'($urandom);
      endcase
      return s;
   endfunction

   task automatic queue_random(input int count);
      stereo_frame_type frame;
      repeat (count) begin
         frame.left  = pick_sample();
         frame.right = pick_sample();
         stim_q.push_back(frame);
      end
   endtask

   // drain the stimulus queue into the request channel
   task automatic send_frames(input int idle_pct);
      stereo_frame_type frame;
      while (stim_q.size() > 0) begin
         frame = stim_q.pop_front();
         while ($urandom_range(99) < idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid    <= 1'b1;
         req_chan.left_in  <= frame.left;
         req_chan.right_in <= frame.right;
         do @(posedge clock); while (!req_chan.ready);
         sent_count++;
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.responses_seen < sent_count) @(posedge clock);
   endtask

   task automatic set_pace(input pace_type pace, output int idle_pct);
      case (pace)
         PACE_SENDER_IDLE: begin
            idle_pct = 75;
            stall_pct <= 0;
         end
         PACE_RECEIVER_STALL: begin
            idle_pct = 0;
            stall_pct <= 75;
         end
         PACE_BOTH_IDLE: begin
            idle_pct = 15;
            stall_pct <= 15;
         end
         default: begin
            idle_pct = 0;
            stall_pct <= 0;
         end
      endcase
   endtask

   // random register settings, biased to short delays so the feedback loop works
   task automatic shuffle_settings();
      int unsigned dly;
      int unsigned gain;
      int unsigned mix;
      case ($urandom_range(9))
         0:       dly = 0;
         1:       dly = REG17_MAX;
         2:       dly = $urandom_range(65, 4000);
         default: dly = $urandom_range(1, 64);
      endcase
      case ($urandom_range(7))
         0:       gain = 0;
         1:       gain = (1 << GAIN_W) - 1;
         default: gain = $urandom_range(0, REG17_MAX);
      endcase
      case ($urandom_range(7))
         0:       mix = 0;
         1:       mix = UNITY_Q16;
         2:       mix = $urandom_range(UNITY_Q16 + 1, REG17_MAX);
         default: mix = $urandom_range(0, UNITY_Q16);
      endcase
      write_csr(CSR_DELAY, dly);
      write_csr(CSR_FEEDBACK, gain);
      write_csr(CSR_MIX, mix);
      if ($urandom_range(3) == 0)
         write_csr(CSR_UNUSED, $urandom_range(0, REG17_MAX));
   endtask

   // main sequence
   initial begin
      int idle_pct;
      sb = new();
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.left_in  <= '0;
      req_chan.right_in <= '0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_DELAY;
      csr_wdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // short delay, top feedback, fully wet: drives the write-back into saturation
      write_csr(CSR_DELAY, 1);
      write_csr(CSR_FEEDBACK, (1 << GAIN_W) - 1);
      write_csr(CSR_MIX, UNITY_Q16);
      write_csr(CSR_UNUSED, REG17_MAX);
      queue_frame(SAMPLE_MAX, SAMPLE_MAX);
      queue_frame(SAMPLE_MAX, SAMPLE_MIN);
      queue_frame(SAMPLE_MAX, SAMPLE_MAX);
      queue_frame(SAMPLE_MIN, SAMPLE_MIN);
      queue_frame(SAMPLE_MIN, SAMPLE_MAX);
      queue_frame(SAMPLE_MIN, SAMPLE_MIN);
      queue_frame(0, 0);
      queue_frame(-1, 1);
      queue_frame(1, -1);
      queue_frame(0, 0);
      send_frames(0);
      wait_drained();

      // zero delay with an unwritten entry, mix above one, no feedback
      write_csr(CSR_DELAY, 0);
      write_csr(CSR_FEEDBACK, 0);
      write_csr(CSR_MIX, REG17_MAX);
      queue_frame(SAMPLE_MAX, SAMPLE_MIN);
      queue_frame(12345, -12345);
      queue_frame(-1, 0);
      queue_frame(SAMPLE_MIN, SAMPLE_MAX);
      queue_frame(0, -1);
      queue_frame(1, 1);
      send_frames(0);
      wait_drained();

      // longest delay, fully dry, feedback write with the unused top bit set
      write_csr(CSR_DELAY, REG17_MAX);
      write_csr(CSR_FEEDBACK, REG17_MAX);
      write_csr(CSR_MIX, 0);
      queue_frame(SAMPLE_MAX, SAMPLE_MIN);
      queue_frame(SAMPLE_MIN, SAMPLE_MAX);
      queue_frame(-2, 2);
      queue_frame(21845, -21846);
      queue_frame(-1, -1);
      queue_frame(0, 0);
      send_frames(0);
      wait_drained();

      // random phases, rotating through the pacing modes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         shuffle_settings();
         set_pace(pace_type'(ph % 4), idle_pct);
         queue_random(PHASE_FRAMES);
         send_frames(idle_pct);
         wait_drained();
      end

      // receiver holds off while requests keep coming, so the block backs up
      write_csr(CSR_DELAY, $urandom_range(1, 8));
      write_csr(CSR_FEEDBACK, $urandom_range(32768, 65535));
      write_csr(CSR_MIX, $urandom_range(0, UNITY_Q16));
      set_pace(PACE_STEADY, idle_pct);
      hold_pending <= 1'b1;
      queue_random(40);
      send_frames(0);
      wait_drained();

      // zero delay over a partly written line
      write_csr(CSR_DELAY, 0);
      write_csr(CSR_FEEDBACK, $urandom_range(0, 65535));
      write_csr(CSR_MIX, $urandom_range(1, UNITY_Q16));
      set_pace(PACE_BOTH_IDLE, idle_pct);
      queue_random(40);
      send_frames(idle_pct);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("stereo_feedback_echo_unit: match");
      else
         $display("stereo_feedback_echo_unit: mismatch");
      $finish;
   end

endmodule

>>> files.f
rtl/sfe_pkg.sv
rtl/sfe_chan_if.sv
rtl/sfe_lane.sv
rtl/stereo_feedback_echo_unit.sv
rtl/sfe_checker.sv
tb/tb.sv
